### sv/button_repeat_timeout_controller_unit_macros.svh
// Assertion macros for the button repeat / timeout controller.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BUTTON_REPEAT_TIMEOUT_CONTROLLER_UNIT_MACROS_SVH
`define BUTTON_REPEAT_TIMEOUT_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BRTC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BRTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/brtc_pkg.sv
// Shared types and constants for the button repeat / timeout controller.
// No dependencies; imported by the top level.
package brtc_pkg;

	typedef enum logic [2:0] {
		REQ_TICK         = 3'd0,
		REQ_DOWN_PRESS   = 3'd1,
		REQ_DOWN_RELEASE = 3'd2,
		REQ_OK_RISE      = 3'd3,
		REQ_OK_FALL      = 3'd4,
		REQ_UP_PRESS     = 3'd5,
		REQ_UP_RELEASE   = 3'd6
	} req_type_t;

	typedef enum logic [1:0] {
		NAV_NONE = 2'd0,
		NAV_DOWN = 2'd1,
		NAV_UP   = 2'd2,
		NAV_OK   = 2'd3
	} nav_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_ENABLED       = 3'd0;
	localparam logic [2:0] CFG_BACK_TIMEOUT  = 3'd1;
	localparam logic [2:0] CFG_DEBOUNCE_TIME = 3'd2;
	localparam logic [2:0] CFG_MAX_REPEAT    = 3'd3;
	localparam logic [2:0] CFG_MIN_REPEAT    = 3'd4;
	localparam logic [2:0] CFG_REACH_LIMIT   = 3'd5;

	// Register reset values
	localparam logic [15:0] RST_BACK_TIMEOUT  = 16'd10000;
	localparam logic [15:0] RST_DEBOUNCE_TIME = 16'd50;
	localparam logic [15:0] RST_MAX_REPEAT    = 16'd500;
	localparam logic [15:0] RST_MIN_REPEAT    = 16'd10;
	localparam logic [15:0] RST_REACH_LIMIT   = 16'd10000;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// ceil(2^17 / 3): floor(x * RECIP_THIRD / 2^17) == floor(x / 3) for x < 2^17
	localparam logic [16:0] RECIP_THIRD = 17'd43691;

	typedef struct packed {
		req_type_t req_type;
		logic      in_range;
		logic      auto_mode;
	} req_t;

	typedef struct packed {
		nav_t nav_event;
		logic back_event;
		logic warning_active;
		logic alarm_raised;
	} rsp_t;

endpackage

### sv/button_repeat_timeout_controller_unit.sv
// The result of an item is registered and presented in the cycle after its transfer.
// Throughput: one item per cycle; the whole state update is one pass of logic per transfer,
//   and the input is stalled only while a finished result is held by a stalled output.
// Repeat period (2/3 of the last one) uses one 17x17 reciprocal multiply in that pass.
// Reset (arst_n low, asynchronous): counters and flags clear, idle count loads 10000,
//   configuration registers take their documented defaults, output goes empty.
module button_repeat_timeout_controller_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  brtc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output brtc_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import brtc_pkg::*;

	`include "button_repeat_timeout_controller_unit_macros.svh"

	function automatic logic [15:0] dec_sat(input logic [15:0] v);
		dec_sat = (v != 16'd0) ? v - 16'd1 : 16'd0;
	endfunction

	// Configuration registers
	logic        enabled_q;
	logic [15:0] back_timeout_q;
	logic [15:0] debounce_time_q;
	logic [15:0] max_repeat_q;
	logic [15:0] min_repeat_q;
	logic [15:0] reach_limit_q;

	// Controller state
	logic [15:0] idle_count_q,      idle_count_d;
	logic [15:0] repeat_count_q,    repeat_count_d;
	logic [15:0] last_period_q,     last_period_d;
	logic [15:0] debounce_count_q,  debounce_count_d;
	logic [15:0] unreached_count_q, unreached_count_d;
	logic        down_held_q,       down_held_d;
	logic        up_held_q,         up_held_d;
	logic        warn_q,            warn_d;

	// Output register
	logic rsp_valid_s1;
	rsp_t rsp_s1;
	rsp_t rsp_d;

	logic req_fire;
	logic rsp_load;

	// Shared repeat-period step: next = clamp(last_period * 2 / 3)
	logic [32:0] third_prod;
	logic [15:0] step_raw;
	logic [15:0] step_period;

	// ------------------------------------------------------------------
	// Handshake: hold the input only while a finished result is stalled.
	// ------------------------------------------------------------------
	assign rsp_load  = !rsp_valid_s1 || !rsp_stall;
	assign req_stall = !rsp_load;
	assign req_fire  = req_valid && !req_stall;

	assign rsp_valid = rsp_valid_s1;
	assign rsp       = rsp_s1;

	// ------------------------------------------------------------------
	// Repeat period: 2*last_period fits 17 bits, so the reciprocal is exact.
	// ------------------------------------------------------------------
	assign third_prod = 33'({last_period_q, 1'b0}) * 33'(RECIP_THIRD);
	assign step_raw   = third_prod[32:17];

	always_comb begin
		if (step_raw < min_repeat_q) begin
			step_period = min_repeat_q;
		end else if (step_raw > max_repeat_q) begin
			step_period = max_repeat_q;
		end else begin
			step_period = step_raw;
		end
	end

	// ------------------------------------------------------------------
	// Per-item state update and result.
	// ------------------------------------------------------------------
	always_comb begin
		logic press;
		logic accept;

		idle_count_d      = idle_count_q;
		repeat_count_d    = repeat_count_q;
		last_period_d     = last_period_q;
		debounce_count_d  = debounce_count_q;
		unreached_count_d = unreached_count_q;
		down_held_d       = down_held_q;
		up_held_d         = up_held_q;
		warn_d            = warn_q;
		rsp_d             = '{nav_event: NAV_NONE, back_event: 1'b0,
		                      warning_active: 1'b0, alarm_raised: 1'b0};

		press  = req.req_type inside {REQ_DOWN_PRESS, REQ_OK_RISE, REQ_UP_PRESS};
		accept = (debounce_count_q == 16'd0) && enabled_q;

		case (req.req_type)
			REQ_TICK: begin
				idle_count_d     = dec_sat(idle_count_q);
				repeat_count_d   = dec_sat(repeat_count_q);
				debounce_count_d = dec_sat(debounce_count_q);

				// Inactivity timeout. A second check after key service could only
				// reload the same value again, so it is folded into this one.
				if (idle_count_d == 16'd0 && !warn_q) begin
					idle_count_d     = back_timeout_q;
					rsp_d.back_event = 1'b1;
				end

				if (enabled_q) begin
					if (req.in_range) begin
						unreached_count_d = 16'd0;
					end else if (req.auto_mode && !warn_q &&
					             unreached_count_q != COUNT_MAX) begin
						unreached_count_d = unreached_count_q + 16'd1;
					end

					// Service held keys; down wins, one event per tick
					if (unreached_count_d < reach_limit_q && !warn_q &&
					    repeat_count_d == 16'd0) begin
						if (down_held_q) begin
							rsp_d.nav_event = NAV_DOWN;
							repeat_count_d  = step_period;
							last_period_d   = step_period;
						end else if (up_held_q) begin
							rsp_d.nav_event = NAV_UP;
							repeat_count_d  = step_period;
							last_period_d   = step_period;
						end
					end

					// Latch the warning
					if (unreached_count_d >= reach_limit_q) begin
						rsp_d.alarm_raised = !warn_q;
						warn_d             = 1'b1;
						unreached_count_d  = 16'd0;
					end
				end
			end
			REQ_DOWN_PRESS, REQ_DOWN_RELEASE, REQ_OK_RISE, REQ_OK_FALL,
			REQ_UP_PRESS, REQ_UP_RELEASE: begin
				if (press && accept && warn_q) begin
					// First accepted press clears the warning and gives a back event, no navigation
					rsp_d.back_event = 1'b1;
					warn_d           = 1'b0;
				end else if (press && accept) begin
					if (req.req_type == REQ_DOWN_PRESS) begin
						rsp_d.nav_event = NAV_DOWN;
					end else if (req.req_type == REQ_UP_PRESS) begin
						rsp_d.nav_event = NAV_UP;
					end else if (repeat_count_q == 16'd0) begin
						rsp_d.nav_event = NAV_OK;
						repeat_count_d  = step_period;
						last_period_d   = step_period;
					end
				end

				// Restart the repeat period on a down or up press, accepted or not
				if (req.req_type == REQ_DOWN_PRESS || req.req_type == REQ_UP_PRESS) begin
					repeat_count_d = max_repeat_q;
					last_period_d  = max_repeat_q;
				end

				if (req.req_type == REQ_DOWN_PRESS)   down_held_d = 1'b1;
				if (req.req_type == REQ_DOWN_RELEASE) down_held_d = 1'b0;
				if (req.req_type == REQ_UP_PRESS)     up_held_d   = 1'b1;
				if (req.req_type == REQ_UP_RELEASE)   up_held_d   = 1'b0;

				idle_count_d      = back_timeout_q;
				debounce_count_d  = debounce_time_q;
				unreached_count_d = 16'd0;
			end
			default: begin
				// Unused request code: no state change, no events
			end
		endcase

		rsp_d.warning_active = warn_d;
	end

	// ------------------------------------------------------------------
	// Configuration writes; indexes beyond the list are dropped.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= 1'b0;
			back_timeout_q  <= RST_BACK_TIMEOUT;
			debounce_time_q <= RST_DEBOUNCE_TIME;
			max_repeat_q    <= RST_MAX_REPEAT;
			min_repeat_q    <= RST_MIN_REPEAT;
			reach_limit_q   <= RST_REACH_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLED:       enabled_q       <= cfg_data[0];
				CFG_BACK_TIMEOUT:  back_timeout_q  <= cfg_data;
				CFG_DEBOUNCE_TIME: debounce_time_q <= cfg_data;
				CFG_MAX_REPEAT:    max_repeat_q    <= cfg_data;
				CFG_MIN_REPEAT:    min_repeat_q    <= cfg_data;
				CFG_REACH_LIMIT:   reach_limit_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// State advances on every input transfer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_count_q      <= RST_BACK_TIMEOUT;
			repeat_count_q    <= 16'd0;
			last_period_q     <= 16'd0;
			debounce_count_q  <= 16'd0;
			unreached_count_q <= 16'd0;
			down_held_q       <= 1'b0;
			up_held_q         <= 1'b0;
			warn_q            <= 1'b0;
		end else if (req_fire) begin
			idle_count_q      <= idle_count_d;
			repeat_count_q    <= repeat_count_d;
			last_period_q     <= last_period_d;
			debounce_count_q  <= debounce_count_d;
			unreached_count_q <= unreached_count_d;
			down_held_q       <= down_held_d;
			up_held_q         <= up_held_d;
			warn_q            <= warn_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register: load on transfer, drop once taken downstream.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_s1 <= req_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_s1 <= rsp_d;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BRTC_ASSERT_IMPL(a_alarm_sets_warning, rsp_valid && rsp.alarm_raised, rsp.warning_active, "alarm without latched warning")
	`BRTC_ASSERT_IMPL(a_no_nav_under_warning, rsp_valid && rsp.warning_active, rsp.nav_event == NAV_NONE, "navigation event while warning latched")
	`BRTC_ASSERT_IMPL(a_warning_cleared_by_press, $fell(warn_q), $past(req_fire) && ($past(req.req_type) == REQ_DOWN_PRESS || $past(req.req_type) == REQ_OK_RISE || $past(req.req_type) == REQ_UP_PRESS), "warning cleared without a press")
	`BRTC_ASSERT_NEXT(a_transfer_gives_result, req_fire, rsp_valid_s1 && rsp_s1.warning_active == warn_q, "transfer did not produce a matching result")

endmodule
